>>> rtl/ssh_pkg.sv
// Package for the selectable string hash: mode codes, finishing kinds and
// the per-byte CRC-32 and one-at-a-time update functions.
// No dependencies.
package ssh_pkg;

  localparam logic [2:0] MODE_SUM   = 3'd0;
  localparam logic [2:0] MODE_LEN   = 3'd1;
  localparam logic [2:0] MODE_FIRST = 3'd2;
  localparam logic [2:0] MODE_ZERO  = 3'd3;
  localparam logic [2:0] MODE_OAAT  = 3'd4;
  localparam logic [2:0] MODE_CRC   = 3'd5;

  localparam logic [1:0] FIN_PLAIN = 2'd0;
  localparam logic [1:0] FIN_OAAT  = 2'd1;
  localparam logic [1:0] FIN_CRC   = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] raw;
  } fin_t;

  function automatic logic [31:0] start_value(input logic [2:0] mode);
    start_value = (mode == MODE_CRC) ? CRC_INIT : 32'd0;
  endfunction

  // Reflected CRC-32 over one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_byte = c;
  endfunction

  function automatic logic [31:0] oaat_step(input logic [31:0] h_in,
                                            input logic [7:0]  b);
    logic [31:0] h;
    h = h_in + {24'd0, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    oaat_step = h;
  endfunction

  function automatic logic [31:0] oaat_mix(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    oaat_mix = h;
  endfunction

  function automatic logic [31:0] finish(input fin_t f);
    case (f.kind)
      FIN_OAAT: finish = oaat_mix(f.raw);
      FIN_CRC:  finish = ~f.raw;
      default:  finish = f.raw;
    endcase
  endfunction

endpackage

>>> rtl/ssh_key_if.sv
// Key channel: one byte of the key string per beat, with present and last flags.
// Stands alone; used by selectable_string_hash.
interface ssh_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

>>> rtl/ssh_hash_if.sv
// Result channel: one 32-bit hash per beat.
// Stands alone; used by selectable_string_hash.
interface ssh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

>>> rtl/selectable_string_hash.sv
// Top level of the selectable string hash (sum, length, first byte, zero,
// one-at-a-time, CRC-32). Depends on ssh_pkg, ssh_key_if and ssh_hash_if.
//
//   channel        direction  beat
//   key_in         sink       data_byte, byte_present, last_byte
//   hash_out       source     hash_value
//   hash_mode_we   in         write strobe for hash_mode_wdata (3 bits)
//
// One key byte is taken every cycle while key_in.ready is high; the byte
// update (eight CRC bit steps or the one-at-a-time shift-adds) sits between
// the state registers. A finished string moves into a finish register, and
// the final mix is done on the way to the output register, which drives
// hash_out. Reset is synchronous and leaves mode 5 selected.
// A stall on hash_out holds both registers and drops key_in.ready only once
// both are full.
module selectable_string_hash
  import ssh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        hash_mode_we,
  input  logic [2:0]  hash_mode_wdata,
  ssh_key_if.sink     key_in,
  ssh_hash_if.source  hash_out
);

  logic [2:0]  hash_mode;
  logic [31:0] running_hash;
  logic [31:0] byte_count;
  logic [7:0]  first_byte;
  logic        in_string;

  fin_t        fin;
  logic        fin_valid;
  logic        out_valid;
  logic [31:0] out_hash;

  logic        fin_ready;
  logic        take;
  logic        ends;
  logic [31:0] base_hash;
  logic [31:0] base_count;
  logic [7:0]  base_first;
  logic [31:0] upd_hash;
  logic [31:0] cnt_next;
  logic [31:0] end_hash;
  logic [31:0] end_count;
  logic [7:0]  end_first;
  fin_t        fin_next;

  assign fin_ready      = !out_valid || hash_out.ready;
  assign key_in.ready   = !fin_valid || fin_ready;
  assign take           = key_in.valid && key_in.ready;
  assign ends           = !key_in.byte_present || key_in.last_byte;
  assign hash_out.valid = out_valid;
  assign hash_out.hash_value = out_hash;

  always_comb begin
    base_hash  = in_string ? running_hash : start_value(hash_mode);
    base_count = in_string ? byte_count : 32'd0;
    base_first = in_string ? first_byte : key_in.data_byte;
    case (hash_mode)
      MODE_SUM:  upd_hash = base_hash + {24'd0, key_in.data_byte};
      MODE_OAAT: upd_hash = oaat_step(base_hash, key_in.data_byte);
      MODE_CRC:  upd_hash = crc_byte(base_hash, key_in.data_byte);
      default:   upd_hash = base_hash;
    endcase
    cnt_next = base_count + 32'd1;

    end_hash  = key_in.byte_present ? upd_hash : running_hash;
    end_count = key_in.byte_present ? cnt_next : byte_count;
    end_first = key_in.byte_present ? base_first : first_byte;

    fin_next.kind = FIN_PLAIN;
    case (hash_mode)
      MODE_SUM:   fin_next.raw = end_hash;
      MODE_LEN:   fin_next.raw = end_count;
      MODE_FIRST: fin_next.raw = {24'd0, end_first};
      MODE_OAAT: begin
        fin_next.raw  = end_hash;
        fin_next.kind = FIN_OAAT;
      end
      MODE_CRC: begin
        fin_next.raw  = end_hash;
        fin_next.kind = FIN_CRC;
      end
      default:    fin_next.raw = 32'd0;
    endcase

    // An empty marker with no bytes seen hashes to zero in every mode.
    if (!key_in.byte_present && !in_string) begin
      fin_next.raw  = 32'd0;
      fin_next.kind = FIN_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode    <= MODE_CRC;
      running_hash <= CRC_INIT;
      byte_count   <= 32'd0;
      first_byte   <= 8'd0;
      in_string    <= 1'b0;
    end else begin
      if (hash_mode_we) begin
        hash_mode <= hash_mode_wdata;
      end
      if (take) begin
        if (!ends) begin
          running_hash <= upd_hash;
          byte_count   <= cnt_next;
          first_byte   <= base_first;
          in_string    <= 1'b1;
        end else begin
          running_hash <= start_value(hash_mode);
          byte_count   <= 32'd0;
          first_byte   <= 8'd0;
          in_string    <= 1'b0;
        end
      end
    end
  end

  // The finish register loads whenever it is empty or draining, so a
  // string that ends while the output is stalled is not lost.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (key_in.ready) begin
        fin_valid <= take && ends;
      end
      if (fin_ready) begin
        out_valid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready) begin
      fin <= fin_next;
    end
    if (fin_ready) begin
      out_hash <= finish(fin);
    end
  end

endmodule
